// ----- rtl/gmau_pkg.sv -----
// Shared types and constants of the guest memory access unit.
// No dependencies; used by guest_memory_access_unit_core.
`default_nettype none

package gmau_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SET   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_WIDTH  = 2'd1,
    ST_RANGE  = 2'd2,
    ST_DENIED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_BASE = 2'd0,
    REG_SIZE = 2'd1,
    REG_SHIFT = 2'd2,
    REG_PERM_EN = 2'd3
  } reg_t;

  localparam logic [1:0] PERM_READ  = 2'b01;
  localparam logic [1:0] PERM_WRITE = 2'b10;

  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 40;

  localparam logic [31:0] BASE_RESET  = 32'd0;
  localparam logic [16:0] SIZE_RESET  = 17'd65536;
  localparam logic [4:0]  SHIFT_RESET = 5'd12;
  localparam logic [4:0]  SHIFT_MIN   = 5'd8;
  localparam logic [4:0]  SHIFT_MAX   = 5'd16;

endpackage

`default_nettype wire

// ----- rtl/guest_memory_access_unit_core.sv -----
// Guest memory access unit: windowed byte memory with a page permission table.
// Depends on gmau_pkg.
`default_nettype none

// Each transaction passes through accept (window offset and wrap add),
// check (window compare, reads of the four byte banks and both pages of the
// permission memory), execute (permission check, write-back, result). The
// result sits in an output register; a stalled result holds execution, and the
// next transaction is taken once execution is done. Guest memory is four byte
// banks of MEM_BYTES/4 rows, so any access of up to four bytes uses each bank
// once. After reset the permission memory is cleared one page per cycle,
// while no transaction is taken; configuration writes are taken at any time.
module guest_memory_access_unit_core #(
  parameter int MEM_BYTES = 65536,
  parameter int MAX_PAGES = 256
) (
  input  wire                        clk,
  input  wire                        rst,
  // transaction in
  input  wire                        s_tvalid,
  output logic                       s_tready,
  // addr[31:0], width_bytes[34:32], write_data[66:35], page_index[74:67],
  // page_perm_value[76:75], zero[79:77]
  input  wire [gmau_pkg::S_TDATA_W-1:0] s_tdata,
  // op[1:0]
  input  wire [1:0]                  s_tuser,
  // result out
  output logic                       m_tvalid,
  input  wire                        m_tready,
  // ok[0], read_data[32:1], status[34:33], zero[39:35]
  output logic [gmau_pkg::M_TDATA_W-1:0] m_tdata,
  // configuration
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [1:0]                  cfg_index,
  input  wire [31:0]                 cfg_data
);
  import gmau_pkg::*;

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int RW   = AW - 2;
  localparam int ROWS = MEM_BYTES / 4;
  localparam int PAW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam logic [31:0] MEM_BYTES_W = 32'(MEM_BYTES);
  localparam logic [31:0] MAX_PAGES_W = 32'(MAX_PAGES);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CHECK, S_EXEC} state_t;
  state_t state;

  // configuration registers
  logic [31:0] window_base;
  logic [16:0] window_size;
  logic [4:0]  page_bits;
  logic        perms_enabled;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base   <= BASE_RESET;
      window_size   <= SIZE_RESET;
      page_bits     <= SHIFT_RESET;
      perms_enabled <= 1'b0;
    end else if (cfg_valid) begin
      case (reg_t'(cfg_index))
        REG_BASE:    window_base   <= cfg_data;
        REG_SIZE:    window_size   <= cfg_data[16:0];
        REG_SHIFT:   page_bits     <= cfg_data[4:0];
        REG_PERM_EN: perms_enabled <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // input fields
  logic [31:0] in_addr;
  logic [2:0]  in_width;
  logic [31:0] in_wdata;
  logic [7:0]  in_pidx;
  logic [1:0]  in_pval;
  assign in_addr  = s_tdata[31:0];
  assign in_width = s_tdata[34:32];
  assign in_wdata = s_tdata[66:35];
  assign in_pidx  = s_tdata[74:67];
  assign in_pval  = s_tdata[76:75];

  logic accept, exec_fire, clr_last;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign exec_fire = (state == S_EXEC) && (!m_tvalid || m_tready);

  // accept stage
  logic [32:0] off_diff, end_sum;
  assign off_diff = {1'b0, in_addr} - {1'b0, window_base};
  assign end_sum  = {1'b0, in_addr} + 33'(in_width - 3'd1);

  op_t         a_op;
  logic [2:0]  a_w;
  logic [31:0] a_data;
  logic [7:0]  a_pidx;
  logic [1:0]  a_pval;
  logic [31:0] a_off;
  logic        a_below, a_wrap;

  always_ff @(posedge clk) begin
    if (accept) begin
      a_op    <= op_t'(s_tuser);
      a_w     <= in_width;
      a_data  <= in_wdata;
      a_pidx  <= in_pidx;
      a_pval  <= in_pval;
      a_off   <= off_diff[31:0];
      a_below <= off_diff[32];
      a_wrap  <= end_sum[32];
    end
  end

  // check stage
  logic [16:0] size_eff;
  logic [4:0]  sh;
  logic [17:0] acc_end;
  logic [16:0] last_off;
  logic [16:0] pg0, pg1;
  logic        width_ok, in_window, pidx_ok;
  status_t     chk_stat;
  logic [RW-1:0] row_base;
  logic [RW-1:0] row_sel [4];

  always_comb begin
    size_eff = ({15'd0, window_size} > MEM_BYTES_W) ? MEM_BYTES_W[16:0] : window_size;
    if (page_bits < SHIFT_MIN)      sh = SHIFT_MIN;
    else if (page_bits > SHIFT_MAX) sh = SHIFT_MAX;
    else                            sh = page_bits;
    acc_end   = {1'b0, a_off[16:0]} + 18'(a_w);
    last_off  = a_off[16:0] + 17'(a_w - 3'd1);
    pg0       = a_off[16:0] >> sh;
    pg1       = last_off >> sh;
    width_ok  = (a_w == 3'd1) || (a_w == 3'd2) || (a_w == 3'd4);
    in_window = !a_below && (size_eff != 17'd0) && (a_off[31:17] == 15'd0) &&
                (acc_end <= {1'b0, size_eff});
    pidx_ok   = {24'd0, a_pidx} < MAX_PAGES_W;
    case (a_op)
      OP_READ, OP_WRITE: begin
        if (!width_ok)                 chk_stat = ST_WIDTH;
        else if (a_wrap || !in_window) chk_stat = ST_RANGE;
        else                           chk_stat = ST_OK;
      end
      OP_SET:  chk_stat = pidx_ok ? ST_OK : ST_RANGE;
      default: chk_stat = ST_WIDTH;
    endcase
    row_base = a_off[AW-1:2];
    for (int b = 0; b < 4; b++) begin
      row_sel[b] = row_base + RW'((b < int'(a_off[1:0])) ? 1 : 0);
    end
  end

  status_t       c_stat;
  logic          c_pg0_ok, c_pg1_ok;
  logic [1:0]    c_lane;
  logic [RW-1:0] c_row [4];

  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      c_stat   <= chk_stat;
      c_pg0_ok <= {15'd0, pg0} < MAX_PAGES_W;
      c_pg1_ok <= {15'd0, pg1} < MAX_PAGES_W;
      c_lane   <= a_off[1:0];
      for (int b = 0; b < 4; b++) c_row[b] <= row_sel[b];
    end
  end

  // permission memory: two read ports, one write port
  logic [1:0]     perm_mem [MAX_PAGES];
  logic [1:0]     perm_q0, perm_q1;
  logic [PAW-1:0] clr_idx;

  assign clr_last = ({{(32-PAW){1'b0}}, clr_idx} == MAX_PAGES_W - 32'd1);

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      perm_mem[clr_idx] <= 2'b00;
    end else if (exec_fire && a_op == OP_SET && c_stat == ST_OK) begin
      perm_mem[PAW'(a_pidx)] <= a_pval;
    end
    if (state == S_CHECK) begin
      perm_q0 <= perm_mem[PAW'(pg0)];
      perm_q1 <= perm_mem[PAW'(pg1)];
    end
  end

  // execute stage
  logic [1:0] need;
  logic       perm_ok, access;
  status_t    fin_stat;
  logic [7:0] bank_q [4];
  logic [7:0] wbyte [4];
  logic [3:0] bank_we;
  logic [31:0] rdata;

  always_comb begin
    need     = (a_op == OP_WRITE) ? PERM_WRITE : PERM_READ;
    access   = (a_op == OP_READ) || (a_op == OP_WRITE);
    perm_ok  = !perms_enabled ||
               (c_pg0_ok && ((perm_q0 & need) == need) &&
                c_pg1_ok && ((perm_q1 & need) == need));
    if (c_stat != ST_OK)           fin_stat = c_stat;
    else if (access && !perm_ok)   fin_stat = ST_DENIED;
    else                           fin_stat = ST_OK;
    rdata = 32'd0;
    for (int i = 0; i < 4; i++) begin
      if (i < int'(a_w)) rdata[8*i +: 8] = bank_q[2'(c_lane + 2'(i))];
    end
    if (a_op != OP_READ || fin_stat != ST_OK) rdata = 32'd0;
    for (int b = 0; b < 4; b++) begin
      wbyte[b]   = a_data[8*int'(2'(2'(b) - c_lane)) +: 8];
      bank_we[b] = exec_fire && a_op == OP_WRITE && fin_stat == ST_OK &&
                   (int'(2'(2'(b) - c_lane)) < int'(a_w));
    end
  end

  // guest byte banks
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0] bank_mem [ROWS];
    always_ff @(posedge clk) begin
      if (bank_we[b]) bank_mem[c_row[b]] <= wbyte[b];
      if (state == S_CHECK) bank_q[b] <= bank_mem[row_sel[b]];
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (exec_fire) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {5'd0, fin_stat, rdata, fin_stat == ST_OK};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + PAW'(1);
          if (clr_last) state <= S_IDLE;
        end
        S_IDLE:  if (accept) state <= S_CHECK;
        S_CHECK: state <= S_EXEC;
        S_EXEC:  if (exec_fire) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for guest_memory_access_unit_core: directed and random
// guest reads, writes and page permission updates against an in-bench predictor.
// Depends on gmau_pkg and the guest_memory_access_unit_core RTL.
module tb_top;
  import gmau_pkg::*;

  localparam int MEM_BYTES = 65536;
  localparam int MAX_PAGES = 256;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    op_t         op;
    logic [31:0] addr;
    logic [2:0]  width;
    logic [31:0] wdata;
    logic [7:0]  page;
    logic [1:0]  perm;
  } access_t;

  typedef struct {
    logic        ok;
    logic [31:0] rdata;
    status_t     status;
  } response_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [1:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // predictor state
  bit [7:0]    guest_mem [MEM_BYTES];
  bit          byte_written [MEM_BYTES];
  bit [1:0]    page_table [MAX_PAGES];
  logic [31:0] win_base = BASE_RESET;
  logic [16:0] win_size = SIZE_RESET;
  logic [4:0]  page_bits = SHIFT_RESET;
  logic        perms_en = 1'b0;

  response_t predicted_responses [$];
  bit        failed = 1'b0;
  bit        idle_on = 1'b1;
  int        stall_left = 0;
  int        quiet_cycles = 0;

  guest_memory_access_unit_core #(
    .MEM_BYTES(MEM_BYTES),
    .MAX_PAGES(MAX_PAGES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Width, window, wrap and page checks; off receives the window offset.
  function automatic status_t check_window_and_perms(input logic [31:0] addr,
                                                     input logic [2:0] w,
                                                     input logic [1:0] need,
                                                     output logic [31:0] off);
    longint unsigned a, o, sz, pg;
    int unsigned sh;
    off = addr - win_base;
    a = addr;
    o = off;
    if (w != 3'd1 && w != 3'd2 && w != 3'd4) return ST_WIDTH;
    if (a + w - 1 > 64'hFFFF_FFFF) return ST_RANGE;
    sz = (win_size > MEM_BYTES) ? MEM_BYTES : win_size;
    if (sz == 0 || addr < win_base) return ST_RANGE;
    if (o + w > sz) return ST_RANGE;
    if (perms_en) begin
      sh = (page_bits < SHIFT_MIN) ? SHIFT_MIN :
           (page_bits > SHIFT_MAX) ? SHIFT_MAX : page_bits;
      for (int i = 0; i < int'(w); i++) begin
        pg = (o + i) >> sh;
        if (pg >= MAX_PAGES) return ST_DENIED;
        if (page_table[pg] == 2'b00 || (page_table[pg] & need) != need) return ST_DENIED;
      end
    end
    return ST_OK;
  endfunction

  function automatic response_t compute_response(input access_t t);
    response_t r;
    logic [31:0] off;
    r.ok = 1'b0;
    r.rdata = '0;
    r.status = ST_OK;
    case (t.op)
      OP_READ: begin
        r.status = check_window_and_perms(t.addr, t.width, PERM_READ, off);
        if (r.status == ST_OK)
          for (int i = 0; i < int'(t.width); i++) r.rdata[8*i +: 8] = guest_mem[off + i];
      end
      OP_WRITE: begin
        r.status = check_window_and_perms(t.addr, t.width, PERM_WRITE, off);
        if (r.status == ST_OK)
          for (int i = 0; i < int'(t.width); i++) begin
            guest_mem[off + i] = t.wdata[8*i +: 8];
            byte_written[off + i] = 1'b1;
          end
      end
      OP_SET: begin
        if (t.page < MAX_PAGES) page_table[t.page] = t.perm;
        else r.status = ST_RANGE;
      end
      default: r.status = ST_WIDTH;
    endcase
    r.ok = (r.status == ST_OK);
    return r;
  endfunction

  function automatic access_t txn(input op_t op, input logic [31:0] addr,
                                  input logic [2:0] width, input logic [31:0] wdata);
    access_t t;
    t.op = op;
    t.addr = addr;
    t.width = width;
    t.wdata = wdata;
    t.page = 8'($urandom);
    t.perm = 2'($urandom_range(0, 3));
    return t;
  endfunction

  function automatic access_t perm_txn(input logic [7:0] page, input logic [1:0] perm);
    access_t t;
    t = txn(OP_SET, $urandom, 3'($urandom_range(0, 7)), $urandom);
    t.page = page;
    t.perm = perm;
    return t;
  endfunction

  function automatic access_t rand_item();
    access_t t;
    int unsigned pick, sz, span;
    sz = (win_size > MEM_BYTES) ? MEM_BYTES : win_size;
    span = (sz < 512) ? sz : 512;
    pick = $urandom_range(0, 99);
    t = txn(OP_READ, '0, '0, $urandom);
    t.op = (pick < 45) ? OP_READ : (pick < 83) ? OP_WRITE : (pick < 95) ? OP_SET : OP_NONE;
    if ($urandom_range(0, 9) == 0) t.width = 3'($urandom_range(0, 7));
    else t.width = 3'd1 << $urandom_range(0, 2);
    pick = $urandom_range(0, 9);
    if (pick == 0 || span == 0) t.addr = $urandom;
    else if (pick == 1) t.addr = win_base + sz - $urandom_range(1, 6);
    else if (pick == 2) t.addr = win_base - $urandom_range(1, 3);
    else t.addr = win_base + $urandom_range(0, span - 1);
    if ($urandom_range(0, 1) == 0) t.page = 8'($urandom_range(0, 3));
    return t;
  endfunction

  // One transaction on the slave side; the expectation is logged at acceptance.
  task automatic send_item(input access_t item);
    access_t t;
    logic [31:0] off;
    t = item;
    // never read bytes that were not written yet: turn such a read into a write
    if (t.op == OP_READ &&
        check_window_and_perms(t.addr, t.width, PERM_READ, off) == ST_OK)
      for (int i = 0; i < int'(t.width); i++)
        if (!byte_written[off + i]) t.op = OP_WRITE;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, t.perm, t.page, t.wdata, t.width, t.addr};
    s_tuser <= t.op;
    do @(posedge clk); while (!s_tready);
    predicted_responses.push_back(compute_response(t));
  endtask

  task automatic await_idle();
    s_tvalid <= 1'b0;
    while (predicted_responses.size() != 0) @(negedge clk);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input reg_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [31:0] base, input logic [31:0] size,
                           input logic [31:0] shift, input logic [31:0] en);
    await_idle();
    put_reg(REG_BASE, base);
    put_reg(REG_SIZE, size);
    put_reg(REG_SHIFT, shift);
    put_reg(REG_PERM_EN, en);
    cfg_valid <= 1'b0;
    win_base = base;
    win_size = size[16:0];
    page_bits = shift[4:0];
    perms_en = en[0];
  endtask

  task automatic test_basic_access();
    logic [2:0] bad_widths [5] = '{3'd0, 3'd3, 3'd5, 3'd6, 3'd7};
    send_item(txn(OP_WRITE, 32'h0, 3'd4, 32'h8765_4321));
    send_item(txn(OP_READ, 32'h3, 3'd1, $urandom));
    send_item(txn(OP_READ, 32'h1, 3'd2, $urandom));
    send_item(txn(OP_READ, 32'h0, 3'd4, $urandom));
    send_item(txn(OP_WRITE, 32'hFFFC, 3'd4, 32'hFFFF_FFFF));
    send_item(txn(OP_READ, 32'hFFFC, 3'd4, $urandom));
    send_item(txn(OP_READ, 32'hFFFF, 3'd2, $urandom));
    send_item(txn(OP_WRITE, 32'hFFFF_FFFF, 3'd2, $urandom));
    send_item(txn(OP_READ, 32'hFFFF_FFFD, 3'd4, $urandom));
    foreach (bad_widths[i]) send_item(txn(OP_WRITE, 32'h0, bad_widths[i], $urandom));
    send_item(txn(OP_NONE, 32'h0, 3'd4, $urandom));
    send_item(perm_txn(8'hFF, 2'b11));
  endtask

  task automatic test_page_perms();
    configure(32'h0, 32'd65536, 32'd8, 32'd1);
    send_item(perm_txn(8'd0, PERM_READ | PERM_WRITE));
    send_item(perm_txn(8'd1, PERM_READ));
    send_item(perm_txn(8'd2, PERM_WRITE));
    send_item(txn(OP_WRITE, 32'hFE, 3'd4, $urandom));
    send_item(txn(OP_WRITE, 32'h200, 3'd1, $urandom));
    send_item(txn(OP_READ, 32'h200, 3'd1, $urandom));
    send_item(txn(OP_READ, 32'h300, 3'd1, $urandom));
    // shift above the top saturates: page 0 then spans the whole window
    configure(32'h0, 32'd65536, 32'd31, 32'd1);
    send_item(txn(OP_READ, 32'h0, 3'd4, $urandom));
    send_item(txn(OP_WRITE, 32'h1FE, 3'd4, $urandom));
  endtask

  task automatic test_window_limits();
    configure(32'hFFFF_0000, 32'h1FFFF, 32'd0, 32'd0);
    send_item(txn(OP_WRITE, 32'hFFFF_FFFF, 3'd1, $urandom));
    send_item(txn(OP_READ, 32'hFFFF_FFFF, 3'd2, $urandom));
    send_item(txn(OP_READ, 32'hFFFE_FFFF, 3'd1, $urandom));
    configure(32'hFFFF_0000, 32'h0, 32'd16, 32'd0);
    send_item(txn(OP_READ, 32'hFFFF_0000, 3'd1, $urandom));
  endtask

  task automatic run_random(input int n);
    repeat (n) send_item(rand_item());
  endtask

  task automatic test_random_traffic();
    configure(32'h0, 32'd65536, 32'd12, 32'd0);
    run_random(150);
    configure(32'h0, 32'd65536, 32'd8, 32'd1);
    run_random(150);
    configure($urandom, $urandom, $urandom_range(0, 31), 32'd0);
    run_random(150);
    configure(32'hFFFF_0000, 32'd65536, 32'd16, 32'd1);
    run_random(150);
    configure($urandom, $urandom_range(1, 64), $urandom_range(0, 31), 32'd1);
    run_random(150);
    configure($urandom_range(0, 255), 32'd65536, $urandom_range(8, 16), $urandom_range(0, 1));
    run_random(150);
    idle_on = 1'b0;
    configure(32'h0, 32'h1FFFF, 32'd10, 32'd1);
    run_random(150);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 13);
    m_tready <= (stall_left == 0);
  end

  always @(posedge clk) begin : check_responses
    response_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.ok = m_tdata[0];
      got.rdata = m_tdata[32:1];
      got.status = status_t'(m_tdata[34:33]);
      if (predicted_responses.size() == 0) begin
        $display("%0t: response with none expected: expected none actual %h", $time, m_tdata);
        failed = 1'b1;
      end else begin
        want = predicted_responses.pop_front();
        if (got.ok !== want.ok) begin
          $display("%0t: ok mismatch: expected %b actual %b", $time, want.ok, got.ok);
          failed = 1'b1;
        end
        if (got.rdata !== want.rdata) begin
          $display("%0t: read_data mismatch: expected %h actual %h", $time, want.rdata,
                   got.rdata);
          failed = 1'b1;
        end
        if (got.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status,
                   got.status);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog: no transaction on any channel for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_basic_access();
    test_page_perms();
    test_window_limits();
    test_random_traffic();
    await_idle();
    repeat (8) @(posedge clk);
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gmau_pkg.sv
rtl/guest_memory_access_unit_core.sv
tb/tb_top.sv
